[design/alre_pkg.sv]
// shared types, constants and word conversion helpers for the array list rotate engine
package alre_pkg;

   localparam int CAPACITY       = 16;
   localparam int WORD_BITS      = 32;
   localparam int IDX_BITS       = $clog2(CAPACITY);
   localparam int LEN_BITS       = $clog2(CAPACITY + 1);
   localparam int PORT_WORD_BITS = 32;
   localparam int ACTION_BITS    = 4;
   localparam int POS_BITS       = 5;
   localparam int FOUND_BITS     = 4;
   localparam int STATUS_BITS    = 2;

   typedef logic [WORD_BITS-1:0] elem_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [LEN_BITS-1:0]  len_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_RESIZE = 4'd0,
      ACT_APPEND = 4'd1,
      ACT_ROTL   = 4'd2,
      ACT_ROTR   = 4'd3,
      ACT_READ   = 4'd4,
      ACT_WRITE  = 4'd5,
      ACT_FIND   = 4'd6,
      ACT_INSERT = 4'd7,
      ACT_FRONT  = 4'd8,
      ACT_BACK   = 4'd9
   } alre_action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } alre_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_WALK,
      S_FINAL
   } alre_state_type;

   // which result the datapath registers on a finish
   typedef enum logic [2:0] {
      RES_NONE,
      RES_EXEC,
      RES_FETCH,
      RES_FIND,
      RES_DONE
   } alre_res_type;

   typedef struct packed {
      logic         capture;
      logic         launch;
      logic         step;
      logic         put_final;
      alre_res_type res;
   } alre_cmd_type;

   typedef struct packed {
      logic exec_now;
      logic fetch;
      logic is_find;
      logic match;
      logic at_last;
   } alre_sts_type;

   function automatic elem_type from_port(logic signed [PORT_WORD_BITS-1:0] w);
      return WORD_BITS'(w);
   endfunction

   function automatic logic signed [PORT_WORD_BITS-1:0] to_port(elem_type e);
      return PORT_WORD_BITS'($signed(e));
   endfunction

endpackage

[design/array_list_rotate_engine.sv]
// top level of the array list rotate engine: controller plus datapath
//
// channel   ports                                   handshake
// request   req_action, req_position, req_word      taken when start is high and busy is low
// response  rsp_read_word, rsp_found_position,      one word per request, valid for the single
//           rsp_status, rsp_length                  cycle that rsp_strobe is high
//
// resize, append, write, unknown actions and every rejected request end in the execute state
// read, front and back: one registered read of the element store, then the fetch state
// rotate (below two elements it ends in execute) and insert walk the store, then write the
// closing element; find walks to a match or the end; the walk moves one element per cycle
// reset clears the length and the per-entry valid bits, so the whole store reads as zero
// the response is never held off; busy stays high while a request is being worked on
module array_list_rotate_engine (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [alre_pkg::ACTION_BITS-1:0]           req_action,
   input  logic [alre_pkg::POS_BITS-1:0]              req_position,
   input  logic signed [alre_pkg::PORT_WORD_BITS-1:0] req_word,
   output logic                                       rsp_strobe,
   output logic signed [alre_pkg::PORT_WORD_BITS-1:0] rsp_read_word,
   output logic [alre_pkg::FOUND_BITS-1:0]            rsp_found_position,
   output logic [alre_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [alre_pkg::LEN_BITS-1:0]              rsp_length
);

   // command and status between sequencer and datapath
   alre_pkg::alre_cmd_type cmd;
   alre_pkg::alre_sts_type sts;

   // sequencer: decides per cycle whether to finish, fetch, walk or write the closing element
   alre_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath: element store with valid bits, walk pointers and the response registers
   alre_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_word           (req_word),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_word      (rsp_read_word),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_length         (rsp_length)
   );

endmodule

[design/alre_ctrl.sv]
// sequencing state machine for the array list rotate engine
module alre_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  alre_pkg::alre_sts_type sts,
   output alre_pkg::alre_cmd_type cmd,
   output logic                  busy
);

   alre_pkg::alre_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alre_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.launch    = 1'b0;
      cmd.step      = 1'b0;
      cmd.put_final = 1'b0;
      cmd.res       = alre_pkg::RES_NONE;
      unique case (state_ff)
         alre_pkg::S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = alre_pkg::S_EXEC;
            end
         end
         alre_pkg::S_EXEC: begin
            if (sts.exec_now) begin
               cmd.res  = alre_pkg::RES_EXEC;
               state_in = alre_pkg::S_IDLE;
            end else if (sts.fetch) begin
               cmd.launch = 1'b1;
               state_in   = alre_pkg::S_FETCH;
            end else begin
               cmd.launch = 1'b1;
               state_in   = alre_pkg::S_WALK;
            end
         end
         alre_pkg::S_FETCH: begin
            cmd.res  = alre_pkg::RES_FETCH;
            state_in = alre_pkg::S_IDLE;
         end
         alre_pkg::S_WALK: begin
            if (sts.is_find) begin
               if (sts.match || sts.at_last) begin
                  cmd.res  = alre_pkg::RES_FIND;
                  state_in = alre_pkg::S_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               cmd.step = 1'b1;
               if (sts.at_last) begin
                  state_in = alre_pkg::S_FINAL;
               end
            end
         end
         alre_pkg::S_FINAL: begin
            cmd.put_final = 1'b1;
            cmd.res       = alre_pkg::RES_DONE;
            state_in      = alre_pkg::S_IDLE;
         end
         default: begin
            state_in = alre_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != alre_pkg::S_IDLE);

endmodule

[design/alre_datapath.sv]
// element store, walk pointers and result registers of the array list rotate engine
module alre_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  alre_pkg::alre_cmd_type                    cmd,
   output alre_pkg::alre_sts_type                    sts,
   input  logic [alre_pkg::ACTION_BITS-1:0]          req_action,
   input  logic [alre_pkg::POS_BITS-1:0]             req_position,
   input  logic signed [alre_pkg::PORT_WORD_BITS-1:0] req_word,
   output logic                                      rsp_strobe,
   output logic signed [alre_pkg::PORT_WORD_BITS-1:0] rsp_read_word,
   output logic [alre_pkg::FOUND_BITS-1:0]           rsp_found_position,
   output logic [alre_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [alre_pkg::LEN_BITS-1:0]             rsp_length
);

   // captured request
   alre_pkg::alre_action_type          act_ff;
   logic [alre_pkg::POS_BITS-1:0]      pos_ff;
   alre_pkg::elem_type                 word_ff;

   // list state
   alre_pkg::elem_type                 mem [alre_pkg::CAPACITY];
   logic [alre_pkg::CAPACITY-1:0]      vld_ff, vld_in;
   alre_pkg::len_type                  len_ff, len_in;

   // walk state
   alre_pkg::idx_type                  prev_ff;
   logic                               last_ff;
   logic                               first_ff;
   alre_pkg::elem_type                 hold_ff;
   alre_pkg::elem_type                 rdata_ff;

   // result registers
   logic                                      rsp_strobe_ff;
   logic signed [alre_pkg::PORT_WORD_BITS-1:0] rsp_read_word_ff, rsp_read_word_in;
   logic [alre_pkg::FOUND_BITS-1:0]           rsp_found_ff, rsp_found_in;
   alre_pkg::alre_status_type                 rsp_status_ff, rsp_status_in;
   alre_pkg::len_type                         rsp_length_ff;

   // decode
   logic                      exec_now, fetch, dir_up, in_range, is_full, is_empty, is_small;
   logic                      is_rotate, is_insert, match;
   alre_pkg::alre_status_type exec_status;
   alre_pkg::idx_type         start_addr, end_addr, final_addr, n_last, pos_idx;
   alre_pkg::idx_type         next_addr, shift_addr;

   // memory port
   logic                      rd_en, wr_en, clear_all, hold_load;
   alre_pkg::idx_type         rd_addr, wr_addr;
   alre_pkg::elem_type        wr_data;

   assign n_last    = alre_pkg::IDX_BITS'(len_ff - 1'b1);
   assign pos_idx   = pos_ff[alre_pkg::IDX_BITS-1:0];
   assign in_range  = int'(pos_ff) < int'(len_ff);
   assign is_full   = int'(len_ff) == alre_pkg::CAPACITY;
   assign is_empty  = len_ff == '0;
   assign is_small  = int'(len_ff) < 2;
   assign is_rotate = (act_ff == alre_pkg::ACT_ROTL) || (act_ff == alre_pkg::ACT_ROTR);
   assign is_insert = act_ff == alre_pkg::ACT_INSERT;
   assign match     = rdata_ff == word_ff;

   always_comb begin
      exec_now    = 1'b1;
      fetch       = 1'b0;
      dir_up      = 1'b0;
      exec_status = alre_pkg::ST_OK;
      start_addr  = '0;
      end_addr    = '0;
      final_addr  = '0;
      unique case (act_ff)
         alre_pkg::ACT_RESIZE: begin
            if (int'(pos_ff) > alre_pkg::CAPACITY) begin
               exec_status = alre_pkg::ST_RANGE;
            end
         end
         alre_pkg::ACT_APPEND: begin
            if (is_full) begin
               exec_status = alre_pkg::ST_FULL;
            end
         end
         alre_pkg::ACT_ROTL: begin
            exec_now   = is_small;
            dir_up     = 1'b1;
            end_addr   = n_last;
            final_addr = n_last;
         end
         alre_pkg::ACT_ROTR: begin
            exec_now   = is_small;
            start_addr = n_last;
         end
         alre_pkg::ACT_READ: begin
            exec_now   = !in_range;
            fetch      = 1'b1;
            start_addr = pos_idx;
            if (!in_range) begin
               exec_status = alre_pkg::ST_RANGE;
            end
         end
         alre_pkg::ACT_WRITE: begin
            if (!in_range) begin
               exec_status = alre_pkg::ST_RANGE;
            end
         end
         alre_pkg::ACT_FIND: begin
            exec_now    = is_empty;
            exec_status = alre_pkg::ST_NOT_FOUND;
            dir_up      = 1'b1;
            end_addr    = n_last;
         end
         alre_pkg::ACT_INSERT: begin
            start_addr = n_last;
            end_addr   = pos_idx;
            final_addr = pos_idx;
            if (!in_range) begin
               exec_status = alre_pkg::ST_RANGE;
            end else if (is_full) begin
               exec_status = alre_pkg::ST_FULL;
            end else begin
               exec_now = 1'b0;
            end
         end
         alre_pkg::ACT_FRONT: begin
            exec_now = is_empty;
            fetch    = 1'b1;
            if (is_empty) begin
               exec_status = alre_pkg::ST_RANGE;
            end
         end
         alre_pkg::ACT_BACK: begin
            exec_now   = is_empty;
            fetch      = 1'b1;
            start_addr = n_last;
            if (is_empty) begin
               exec_status = alre_pkg::ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   // walk goes up for rotate left and find, down otherwise; moved words land one step behind
   assign next_addr  = dir_up ? prev_ff + 1'b1 : prev_ff - 1'b1;
   assign shift_addr = dir_up ? prev_ff - 1'b1 : prev_ff + 1'b1;

   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = start_addr;
      wr_en     = 1'b0;
      wr_addr   = final_addr;
      wr_data   = word_ff;
      clear_all = 1'b0;
      hold_load = 1'b0;
      len_in    = len_ff;
      if (cmd.launch) begin
         rd_en = 1'b1;
      end
      if (cmd.step) begin
         if (!last_ff) begin
            rd_en   = 1'b1;
            rd_addr = next_addr;
         end
         if (act_ff != alre_pkg::ACT_FIND) begin
            if (first_ff && is_rotate) begin
               hold_load = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = shift_addr;
               wr_data = rdata_ff;
            end
         end
      end
      if (cmd.put_final) begin
         wr_en   = 1'b1;
         wr_addr = final_addr;
         wr_data = is_insert ? word_ff : hold_ff;
         if (is_insert) begin
            len_in = len_ff + 1'b1;
         end
      end
      if ((cmd.res == alre_pkg::RES_EXEC) && (exec_status == alre_pkg::ST_OK)) begin
         unique case (act_ff)
            alre_pkg::ACT_RESIZE: begin
               clear_all = 1'b1;
               len_in    = alre_pkg::LEN_BITS'(pos_ff);
            end
            alre_pkg::ACT_APPEND: begin
               wr_en   = 1'b1;
               wr_addr = alre_pkg::IDX_BITS'(len_ff);
               len_in  = len_ff + 1'b1;
            end
            alre_pkg::ACT_WRITE: begin
               wr_en   = 1'b1;
               wr_addr = pos_idx;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      vld_in = clear_all ? '0 : vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      rsp_read_word_in = '0;
      rsp_found_in     = '0;
      rsp_status_in    = alre_pkg::ST_OK;
      case (cmd.res)
         alre_pkg::RES_EXEC: begin
            rsp_status_in = exec_status;
         end
         alre_pkg::RES_FETCH: begin
            rsp_read_word_in = alre_pkg::to_port(rdata_ff);
         end
         alre_pkg::RES_FIND: begin
            if (match) begin
               rsp_found_in = alre_pkg::FOUND_BITS'(prev_ff);
            end else begin
               rsp_status_in = alre_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         len_ff        <= len_in;
         rsp_strobe_ff <= cmd.res != alre_pkg::RES_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= alre_pkg::alre_action_type'(req_action);
         pos_ff  <= req_position;
         word_ff <= alre_pkg::from_port(req_word);
      end
      if (cmd.launch) begin
         prev_ff  <= start_addr;
         last_ff  <= start_addr == end_addr;
         first_ff <= 1'b1;
      end else if (cmd.step) begin
         prev_ff  <= next_addr;
         last_ff  <= next_addr == end_addr;
         first_ff <= 1'b0;
      end
      if (hold_load) begin
         hold_ff <= rdata_ff;
      end
      if (cmd.res != alre_pkg::RES_NONE) begin
         rsp_read_word_ff <= rsp_read_word_in;
         rsp_found_ff     <= rsp_found_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_length_ff    <= len_in;
      end
   end

   assign sts.exec_now = exec_now;
   assign sts.fetch    = fetch;
   assign sts.is_find  = act_ff == alre_pkg::ACT_FIND;
   assign sts.match    = match;
   assign sts.at_last  = last_ff;

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_read_word      = rsp_read_word_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_length         = rsp_length_ff;

endmodule

[verif/tb.sv]
// testbench for the array list rotate engine: directed table, random requests, list predictor
module tb;
   import alre_pkg::*;

   // action codes the block ignores
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED_LO = 4'd10;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED_HI = 4'd15;

   localparam int RANDOM_WORDS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic signed [PORT_WORD_BITS-1:0] read_word;
      logic [FOUND_BITS-1:0]            found_position;
      logic [STATUS_BITS-1:0]           status;
      len_type                          length;
   } outcome_type;

   // one sent word, with an outcome typed in by hand when known
   typedef struct {
      bit          typed;
      outcome_type outcome;
   } sent_word_type;

   // one row of the directed table
   typedef struct {
      logic [ACTION_BITS-1:0]           action;
      logic [POS_BITS-1:0]              position;
      logic signed [PORT_WORD_BITS-1:0] word;
      bit                               typed;
      outcome_type                      outcome;
   } step_row_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [ACTION_BITS-1:0]             req_action;
   logic [POS_BITS-1:0]                req_position;
   logic signed [PORT_WORD_BITS-1:0]   req_word;
   logic                               rsp_strobe;
   logic signed [PORT_WORD_BITS-1:0]   rsp_read_word;
   logic [FOUND_BITS-1:0]              rsp_found_position;
   logic [STATUS_BITS-1:0]             rsp_status;
   logic [LEN_BITS-1:0]                rsp_length;

   // predictor copy of the list
   elem_type      list_store [CAPACITY];
   int            list_len;

   outcome_type   outcome_queue [$];
   sent_word_type sent_queue [$];
   step_row_type  step_table [$];

   int  mismatches;
   int  responses_seen;
   int  words_taken;
   int  longest_list;
   int  cycles;
   int  action_hits [16];
   bit  idling_on;

   array_list_rotate_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_word           (req_word),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_word      (rsp_read_word),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_length         (rsp_length)
   );

   // 2 time unit clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // watchdog, counts from time zero so reset is included
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycles, outcome_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // predictor: apply one request to the list copy and work out its response
   task automatic list_apply(input logic [ACTION_BITS-1:0] action,
                             input logic [POS_BITS-1:0] pos,
                             input logic signed [PORT_WORD_BITS-1:0] word,
                             output outcome_type res);
      elem_type held;
      elem_type w;
      int       n;
      int       i;
      res = '0;
      n   = list_len;
      w   = elem_type'(word);
      case (action)
         ACT_RESIZE: begin
            // too large leaves everything alone, otherwise the store is wiped
            if (pos > CAPACITY) begin
               res.status = ST_RANGE;
            end else begin
               for (i = 0; i < CAPACITY; i++) list_store[i] = '0;
               n = pos;
            end
         end
         ACT_APPEND: begin
            if (n >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_store[n] = w;
               n++;
            end
         end
         ACT_ROTL: begin
            // one element or none: nothing moves
            if (n > 1) begin
               held = list_store[0];
               for (i = 0; i + 1 < n; i++) list_store[i] = list_store[i+1];
               list_store[n-1] = held;
            end
         end
         ACT_ROTR: begin
            if (n > 1) begin
               held = list_store[n-1];
               for (i = n - 1; i > 0; i--) list_store[i] = list_store[i-1];
               list_store[0] = held;
            end
         end
         ACT_READ: begin
            if (pos >= n) res.status = ST_RANGE;
            else res.read_word = $signed(list_store[pos]);
         end
         ACT_WRITE: begin
            if (pos >= n) res.status = ST_RANGE;
            else list_store[pos] = w;
         end
         ACT_FIND: begin
            // lowest matching index wins
            res.status = ST_NOT_FOUND;
            for (i = 0; i < n && res.status == ST_NOT_FOUND; i++) begin
               if (list_store[i] == w) begin
                  res.found_position = FOUND_BITS'(i);
                  res.status         = ST_OK;
               end
            end
         end
         ACT_INSERT: begin
            // index must name an existing element, then the store must have room
            if (pos >= n) begin
               res.status = ST_RANGE;
            end else if (n >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = n; i > pos; i--) list_store[i] = list_store[i-1];
               list_store[pos] = w;
               n++;
            end
         end
         ACT_FRONT: begin
            if (n == 0) res.status = ST_RANGE;
            else res.read_word = $signed(list_store[0]);
         end
         ACT_BACK: begin
            if (n == 0) res.status = ST_RANGE;
            else res.read_word = $signed(list_store[n-1]);
         end
         default: begin
            // unknown actions only report the length
         end
      endcase
      list_len   = n;
      res.length = len_type'(n);
   endtask

   task automatic report_mismatch(input string what, input outcome_type want,
                                  input outcome_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at cycle %0d: %s", cycles, what);
         $display("  expected read_word %h found %0d status %0d length %0d",
                  want.read_word, want.found_position, want.status, want.length);
         $display("  actual   read_word %h found %0d status %0d length %0d",
                  got.read_word, got.found_position, got.status, got.length);
      end
   endtask

   // sample both channels at the rising edge; the response retires before a new word queues
   always @(posedge clock) begin
      outcome_type   got;
      outcome_type   want;
      outcome_type   predicted;
      sent_word_type sent;
      string         what;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_read_word, rsp_found_position, rsp_status, rsp_length};
            responses_seen++;
            if (outcome_queue.size() == 0) begin
               report_mismatch("response with nothing outstanding", '0, got);
            end else begin
               want = outcome_queue.pop_front();
               what = "";
               if (got.read_word !== want.read_word) what = {what, " read_word"};
               if (got.found_position !== want.found_position) what = {what, " found_position"};
               if (got.status !== want.status) what = {what, " status"};
               if (got.length !== want.length) what = {what, " length"};
               if (what != "") report_mismatch({"field", what}, want, got);
            end
         end
         if (start && !busy) begin
            list_apply(req_action, req_position, req_word, predicted);
            if (list_len > longest_list) longest_list = list_len;
            action_hits[req_action]++;
            words_taken++;
            if (sent_queue.size() > 0) begin
               sent = sent_queue.pop_front();
               outcome_queue.insert(outcome_queue.size(), sent.typed ? sent.outcome : predicted);
            end else begin
               outcome_queue.insert(outcome_queue.size(), predicted);
            end
         end
      end
   end

   // drive one word from a falling edge and hold it until it is taken
   task automatic send_word(input logic [ACTION_BITS-1:0] action,
                            input logic [POS_BITS-1:0] pos,
                            input logic signed [PORT_WORD_BITS-1:0] word,
                            input bit typed, input outcome_type outcome);
      sent_word_type sent;
      while (idling_on && $urandom_range(99) < 21) begin
         start = 1'b0;
         @(negedge clock);
      end
      sent.typed   = typed;
      sent.outcome = outcome;
      sent_queue.insert(sent_queue.size(), sent);
      start        = 1'b1;
      req_action   = action;
      req_position = pos;
      req_word     = word;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // sender stops until every response is back
   task automatic wait_quiet();
      start = 1'b0;
      while (outcome_queue.size() > 0 || sent_queue.size() > 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [ACTION_BITS-1:0] action,
                          input logic [POS_BITS-1:0] pos,
                          input logic signed [PORT_WORD_BITS-1:0] word,
                          input bit typed, input logic signed [PORT_WORD_BITS-1:0] rd,
                          input alre_status_type status, input int len);
      step_row_type row;
      row.action   = action;
      row.position = pos;
      row.word     = word;
      row.typed    = typed;
      row.outcome  = '{rd, '0, status, len_type'(len)};
      step_table.insert(step_table.size(), row);
   endtask

   function automatic logic signed [PORT_WORD_BITS-1:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3:       return PORT_WORD_BITS'($urandom_range(3));
         default: return $signed(PORT_WORD_BITS'($urandom));
      endcase
   endfunction

   // mostly a live index, now and then anything the port allows
   function automatic logic [POS_BITS-1:0] pick_index();
      if (list_len == 0 || $urandom_range(7) == 0) return POS_BITS'($urandom_range(31));
      return POS_BITS'($urandom_range(list_len - 1));
   endfunction

   // random request, weighted so the list fills, rotates and gets searched
   task automatic send_random();
      logic [ACTION_BITS-1:0]           act;
      logic [POS_BITS-1:0]              pos;
      logic signed [PORT_WORD_BITS-1:0] w;
      int                               r;
      r   = $urandom_range(99);
      w   = pick_word();
      pos = pick_index();
      if (r < 6) begin
         act = ACT_RESIZE;
         // sometimes past capacity to hit the rejected resize
         if ($urandom_range(9) == 0) pos = POS_BITS'($urandom_range(31, CAPACITY + 1));
         else pos = POS_BITS'($urandom_range(CAPACITY));
      end else if (r < 26) begin
         act = ACT_APPEND;
      end else if (r < 33) begin
         act = ACT_ROTL;
      end else if (r < 40) begin
         act = ACT_ROTR;
      end else if (r < 52) begin
         act = ACT_READ;
      end else if (r < 62) begin
         act = ACT_WRITE;
      end else if (r < 74) begin
         act = ACT_FIND;
         // search for something stored more often than not
         if (list_len > 0 && $urandom_range(9) < 6) begin
            w = $signed(list_store[$urandom_range(list_len - 1)]);
         end
      end else if (r < 86) begin
         act = ACT_INSERT;
      end else if (r < 91) begin
         act = ACT_FRONT;
      end else if (r < 96) begin
         act = ACT_BACK;
      end else begin
         act = ACTION_BITS'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      send_word(act, pos, w, 1'b0, '0);
   endtask

   initial begin
      int i;
      cycles         = 0;
      mismatches     = 0;
      responses_seen = 0;
      words_taken    = 0;
      longest_list   = 0;
      list_len       = 0;
      idling_on      = 1'b1;
      for (i = 0; i < CAPACITY; i++) list_store[i] = '0;
      for (i = 0; i < 16; i++) action_hits[i] = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = '0;
      req_position = '0;
      req_word     = '0;

      // empty list corners, then the extremes of length and word
      add_row(ACT_FRONT,  0,  0,            1, 0,            ST_RANGE,     0);
      add_row(ACT_BACK,   0,  0,            1, 0,            ST_RANGE,     0);
      add_row(ACT_ROTL,   0,  0,            1, 0,            ST_OK,        0);
      add_row(ACT_FIND,   0,  0,            1, 0,            ST_NOT_FOUND, 0);
      add_row(ACT_READ,   0,  0,            1, 0,            ST_RANGE,     0);
      add_row(ACT_INSERT, 0,  5,            1, 0,            ST_RANGE,     0);
      add_row(ACT_RESIZE, 17, 0,            1, 0,            ST_RANGE,     0);
      add_row(ACT_RESIZE, 31, 0,            1, 0,            ST_RANGE,     0);
      add_row(ACT_APPEND, 0,  32'sh8000_0000, 1, 0,          ST_OK,        1);
      add_row(ACT_ROTR,   0,  0,            1, 0,            ST_OK,        1);
      add_row(ACT_FRONT,  0,  0,            1, 32'sh8000_0000, ST_OK,      1);
      add_row(ACT_RESIZE, 16, 0,            1, 0,            ST_OK,        16);
      add_row(ACT_APPEND, 0,  5,            1, 0,            ST_FULL,      16);
      add_row(ACT_INSERT, 0,  9,            1, 0,            ST_FULL,      16);
      add_row(ACT_INSERT, 16, 9,            1, 0,            ST_RANGE,     16);
      add_row(ACT_WRITE,  15, 32'sh7fff_ffff, 1, 0,          ST_OK,        16);
      add_row(ACT_BACK,   0,  0,            1, 32'sh7fff_ffff, ST_OK,      16);
      add_row(ACT_READ,   31, 0,            1, 0,            ST_RANGE,     16);
      // full length rotations and a search, then a short list and unknown actions, left to the predictor
      add_row(ACT_ROTL,   0,  0,            0, 0, ST_OK, 0);
      add_row(ACT_FIND,   0,  32'sh7fff_ffff, 0, 0, ST_OK, 0);
      add_row(ACT_ROTR,   0,  0,            0, 0, ST_OK, 0);
      add_row(ACT_BACK,   0,  0,            0, 0, ST_OK, 0);
      add_row(ACT_RESIZE, 2,  0,            0, 0, ST_OK, 0);
      add_row(ACT_WRITE,  1,  -32'sd1,      0, 0, ST_OK, 0);
      add_row(ACT_INSERT, 1,  32'sh5555_aaaa, 0, 0, ST_OK, 0);
      add_row(ACT_FIND,   0,  -32'sd1,      0, 0, ST_OK, 0);
      add_row(ACT_UNUSED_LO, 0, 0,          0, 0, ST_OK, 0);
      add_row(ACT_UNUSED_HI, 31, -32'sd1,   0, 0, ST_OK, 0);

      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (step_table[k]) begin
         send_word(step_table[k].action, step_table[k].position, step_table[k].word,
                   step_table[k].typed, step_table[k].outcome);
      end
      wait_quiet();

      for (i = 0; i < RANDOM_WORDS; i++) begin
         // a long stretch of back to back requests
         idling_on = !(i >= 300 && i < 450);
         if (i == RANDOM_WORDS / 2) wait_quiet();
         send_random();
      end
      wait_quiet();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests taken (%0d from the table), %0d responses, longest list %0d",
               words_taken, step_table.size(), responses_seen, longest_list);
      $display("resize %0d append %0d rotate %0d read %0d write %0d find %0d insert %0d",
               action_hits[ACT_RESIZE], action_hits[ACT_APPEND],
               action_hits[ACT_ROTL] + action_hits[ACT_ROTR], action_hits[ACT_READ],
               action_hits[ACT_WRITE], action_hits[ACT_FIND], action_hits[ACT_INSERT]);
      if (outcome_queue.size() > 0) begin
         $display("%0d responses never arrived", outcome_queue.size());
      end
      if (mismatches == 0 && outcome_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
